// ----- hdl/pal_pkg.sv -----
// Shared constants, codes and types for the positional array list.
// Used by pal_cell and positional_array_list; depends on nothing else.
`default_nettype none

package pal_pkg;

    // Storage dimensions.
    localparam int CAPACITY   = 64;
    localparam int ITEM_WIDTH = 32;

    // Widths that follow from the storage dimensions.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);

    // Fixed field widths of the stream payloads.
    localparam int MODE_W   = 2;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    // Width used when comparing a position against the length.
    localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_BITS = MODE_W + POS_W + ITEM_WIDTH;
    localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS = STATUS_W + ITEM_WIDTH + LEN_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // Operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic             ins;   // accepted insert, entries at and above slot move up
        logic             del;   // accepted delete, entries above slot move down
        logic [IDX_W-1:0] slot;  // zero-based target slot
    } pal_ctrl_t;

endpackage : pal_pkg

`default_nettype wire

// ----- hdl/pal_cell.sv -----
// One storage cell of the list row: holds one entry and trades it with its neighbors.
// Depends on pal_pkg for widths and the control struct.
`default_nettype none

module pal_cell (
    input  wire logic                          aclk,
    input  wire logic [pal_pkg::IDX_W-1:0]     cell_idx,   // fixed place of this cell
    input  wire pal_pkg::pal_ctrl_t            ctrl,
    input  wire logic [pal_pkg::ITEM_WIDTH-1:0] new_value,
    input  wire logic [pal_pkg::ITEM_WIDTH-1:0] lower_value, // entry of the cell below
    input  wire logic [pal_pkg::ITEM_WIDTH-1:0] upper_value, // entry of the cell above
    output logic      [pal_pkg::ITEM_WIDTH-1:0] entry_value,
    output logic      [pal_pkg::ITEM_WIDTH-1:0] hit_value    // entry if slot matches, else zero
);

    logic [pal_pkg::ITEM_WIDTH-1:0] data_reg;
    logic [pal_pkg::ITEM_WIDTH-1:0] data_next;
    logic                           is_slot;
    logic                           above_slot;

    // Position of this cell relative to the target slot.
    assign is_slot    = (cell_idx == ctrl.slot);
    assign above_slot = (cell_idx > ctrl.slot);

    // Insert loads the new word at the slot and shifts higher cells up;
    // delete pulls the upper neighbor into the slot and every cell above it.
    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (is_slot) begin
                data_next = new_value;
            end else if (above_slot) begin
                data_next = lower_value;
            end
        end else if (ctrl.del) begin
            if (is_slot || above_slot) begin
                data_next = upper_value;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign entry_value = data_reg;
    assign hit_value   = is_slot ? data_reg : '0;

endmodule : pal_cell

`default_nettype wire

// ----- hdl/positional_array_list.sv -----
// Top level of the positional array list: request decode, length counter,
// result register and the row of pal_cell storage cells. Depends on pal_pkg and pal_cell.
//
// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid / s_tready   s_tdata: mode, position, item_value
// m_       out  m_tvalid / m_tready   m_tdata: status, read_value, list_length
//
// At the accepting clock edge an insert or delete shifts the cell row entries from the
// target slot upward, and the result is loaded into the output register at
// that same edge and offered on m_ from the next cycle. A new transaction is accepted
// every cycle while the output register is empty or being drained. A stalled m_ side
// holds the result and stops s_ intake.
// Reset clears the length and the output valid; entry contents are not cleared.
`default_nettype none

module positional_array_list (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata from bit 0 up: mode[1:0], position[8:2], item_value[40:9], zero fill
    input  wire logic [pal_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata from bit 0 up: status[1:0], read_value[33:2], list_length[40:34], zero fill
    output logic      [pal_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int POS_LO = pal_pkg::MODE_W;
    localparam int VAL_LO = pal_pkg::MODE_W + pal_pkg::POS_W;
    localparam int RD_LO  = pal_pkg::STATUS_W;
    localparam int LEN_LO = pal_pkg::STATUS_W + pal_pkg::ITEM_WIDTH;

    // Unpacked request fields.
    pal_pkg::mode_t                  req_mode;
    logic [pal_pkg::POS_W-1:0]       req_pos;
    logic [pal_pkg::ITEM_WIDTH-1:0]  req_value;

    logic                            accept;
    logic [pal_pkg::LEN_W-1:0]       length_reg;
    logic [pal_pkg::LEN_W-1:0]       length_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    pal_pkg::status_t                status_reg;
    pal_pkg::status_t                status_next;
    logic [pal_pkg::ITEM_WIDTH-1:0]  rd_reg;
    logic [pal_pkg::ITEM_WIDTH-1:0]  rd_next;

    logic [pal_pkg::CMP_W-1:0]       pos_cmp;
    logic [pal_pkg::CMP_W-1:0]       len_cmp;
    logic                            list_empty;
    logic                            list_full;
    logic                            pos_in_list;
    logic                            pos_in_ins;
    logic [pal_pkg::POS_W-1:0]       pos_m1;
    logic                            do_read;
    pal_pkg::pal_ctrl_t              ctrl;
    logic [pal_pkg::ITEM_WIDTH-1:0]  read_word;

    logic [pal_pkg::ITEM_WIDTH-1:0]  entry_bus [pal_pkg::CAPACITY];
    logic [pal_pkg::ITEM_WIDTH-1:0]  hit_bus   [pal_pkg::CAPACITY];

    assign req_mode  = pal_pkg::mode_t'(s_tdata[pal_pkg::MODE_W-1:0]);
    assign req_pos   = s_tdata[VAL_LO-1:POS_LO];
    assign req_value = s_tdata[VAL_LO+pal_pkg::ITEM_WIDTH-1:VAL_LO];

    // Input is taken whenever the result register is free or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Position checks against the current length.
    assign pos_cmp     = pal_pkg::CMP_W'(req_pos);
    assign len_cmp     = pal_pkg::CMP_W'(length_reg);
    assign list_empty  = (length_reg == '0);
    assign list_full   = (len_cmp == pal_pkg::CMP_W'(pal_pkg::CAPACITY));
    assign pos_in_list = (pos_cmp != '0) && (pos_cmp <= len_cmp);
    assign pos_in_ins  = (pos_cmp != '0) && (pos_cmp <= len_cmp + pal_pkg::CMP_W'(1));
    assign pos_m1      = req_pos - pal_pkg::POS_W'(1);

    // Request decode: status, length update and the control for the cell row.
    always_comb begin
        status_next = pal_pkg::ST_BADPOS;
        length_next = length_reg;
        do_read     = 1'b0;
        ctrl.ins    = 1'b0;
        ctrl.del    = 1'b0;
        ctrl.slot   = pos_m1[pal_pkg::IDX_W-1:0];
        case (req_mode)
            pal_pkg::MODE_READ: begin
                if (list_empty) begin
                    status_next = pal_pkg::ST_EMPTY;
                end else if (pos_in_list) begin
                    status_next = pal_pkg::ST_OK;
                    do_read     = 1'b1;
                end
            end
            pal_pkg::MODE_INSERT: begin
                if (list_full) begin
                    status_next = pal_pkg::ST_FULL;
                end else if (pos_in_ins) begin
                    status_next = pal_pkg::ST_OK;
                    ctrl.ins    = accept;
                    if (accept) begin
                        length_next = length_reg + pal_pkg::LEN_W'(1);
                    end
                end
            end
            pal_pkg::MODE_DELETE: begin
                if (list_empty) begin
                    status_next = pal_pkg::ST_EMPTY;
                end else if (pos_in_list) begin
                    status_next = pal_pkg::ST_OK;
                    ctrl.del    = accept;
                    if (accept) begin
                        length_next = length_reg - pal_pkg::LEN_W'(1);
                    end
                end
            end
            default: begin
                status_next = pal_pkg::ST_BADPOS;
            end
        endcase
    end

    // Row of storage cells, each trading entries with its neighbors.
    for (genvar gi = 0; gi < pal_pkg::CAPACITY; gi++) begin : g_cell
        logic [pal_pkg::ITEM_WIDTH-1:0] lower_w;
        logic [pal_pkg::ITEM_WIDTH-1:0] upper_w;

        if (gi == 0) begin : g_first
            assign lower_w = req_value;
        end else begin : g_mid_lo
            assign lower_w = entry_bus[gi-1];
        end
        if (gi == pal_pkg::CAPACITY - 1) begin : g_last
            assign upper_w = '0;
        end else begin : g_mid_hi
            assign upper_w = entry_bus[gi+1];
        end

        pal_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (pal_pkg::IDX_W'(gi)),
            .ctrl        (ctrl),
            .new_value   (req_value),
            .lower_value (lower_w),
            .upper_value (upper_w),
            .entry_value (entry_bus[gi]),
            .hit_value   (hit_bus[gi])
        );
    end

    // Only the addressed cell drives a nonzero word, so an OR gathers the read.
    always_comb begin
        read_word = '0;
        for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
            read_word = read_word | hit_bus[i];
        end
    end

    assign rd_next = do_read ? read_word : '0;

    // Output valid follows accepts and drains on m_ transactions.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            length_reg    <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            length_reg    <= length_next;
        end
    end

    // Result payload, loaded on each accepted transaction.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    // The reported length is the length register itself, which already
    // reflects the last accepted operation.
    assign m_tvalid = out_valid_reg;
    always_comb begin
        m_tdata = '0;
        m_tdata[pal_pkg::STATUS_W-1:0]                 = status_reg;
        m_tdata[LEN_LO-1:RD_LO]                        = rd_reg;
        m_tdata[LEN_LO+pal_pkg::LEN_W-1:LEN_LO]        = length_reg;
    end

endmodule : positional_array_list

`default_nettype wire

// ----- bench/pal_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the positional array list: keeps a shadow copy of the list,
// predicts every result and compares it with the m_ channel. Depends on pal_pkg.

module pal_result_checker
    import pal_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_DATA_W-1:0]  m_tdata,
    output int                        error_count,
    output int                        awaited,
    output int                        tracked_length
);

    // Field offsets inside the packed payloads.
    localparam int POS_LSB = MODE_W;
    localparam int VAL_LSB = MODE_W + POS_W;
    localparam int RD_LSB  = STATUS_W;
    localparam int LEN_LSB = STATUS_W + ITEM_WIDTH;

    typedef struct packed {
        status_t               status;
        logic [ITEM_WIDTH-1:0] read_value;
        logic [LEN_W-1:0]      list_length;
    } list_result_t;

    logic [ITEM_WIDTH-1:0] shadow_entries [CAPACITY];
    int                    shadow_len;
    list_result_t          awaited_results [$];

    initial begin
        error_count    = 0;
        awaited        = 0;
        tracked_length = 0;
        shadow_len     = 0;
        foreach (shadow_entries[i]) shadow_entries[i] = '0;
    end

    // Apply one request to the shadow list and return the result it should produce.
    // Emptiness and fullness take priority over the position check.
    function automatic list_result_t apply_list_op(input mode_t op, input int pos,
                                                   input logic [ITEM_WIDTH-1:0] word);
        list_result_t r;
        r.status     = ST_BADPOS;
        r.read_value = '0;
        case (op)
            MODE_READ: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= 1 && pos <= shadow_len) begin
                    r.read_value = shadow_entries[pos-1];
                    r.status     = ST_OK;
                end
            end
            MODE_INSERT: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos >= 1 && pos <= shadow_len + 1) begin
                    for (int i = shadow_len; i >= pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos-1] = word;
                    shadow_len++;
                    r.status = ST_OK;
                end
            end
            MODE_DELETE: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= 1 && pos <= shadow_len) begin
                    // Entries above the hole move down; the shift ends at the last valid one.
                    for (int i = pos - 1; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.list_length = shadow_len[LEN_W-1:0];
        return r;
    endfunction

    // Report one field that differs from its prediction.
    function automatic bit field_ok(input string label, input longint unsigned want,
                                    input longint unsigned got);
        if (want == got) return 1'b1;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        return 1'b0;
    endfunction

    // Results are checked before the same edge's request is predicted, because a
    // result always belongs to a transaction accepted at an earlier edge.
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status      = status_t'(m_tdata[STATUS_W-1:0]);
                got.read_value  = m_tdata[RD_LSB +: ITEM_WIDTH];
                got.list_length = m_tdata[LEN_LSB +: LEN_W];
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual status %0h",
                             $time, got.status);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (!field_ok("status", want.status, got.status))
                        error_count++;
                    if (!field_ok("read_value", want.read_value, got.read_value))
                        error_count++;
                    if (!field_ok("list_length", want.list_length, got.list_length))
                        error_count++;
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_list_op(mode_t'(s_tdata[MODE_W-1:0]),
                                                        int'(s_tdata[POS_LSB +: POS_W]),
                                                        s_tdata[VAL_LSB +: ITEM_WIDTH]));
        end
        awaited        = awaited_results.size();
        tracked_length = shadow_len;
    end

endmodule

// ----- bench/positional_array_list_tb.sv -----
`timescale 1ns / 100ps
// Top of the positional array list bench: clock, reset, request stimulus and the
// m_ side stalls. Depends on pal_pkg, positional_array_list and pal_result_checker.

module positional_array_list_tb;
    import pal_pkg::*;

    localparam int TOTAL_ITEMS = 1775;
    localparam int QUIET_FROM  = 1550;

    typedef enum int {RUN_GROW, RUN_SHRINK, RUN_FILL, RUN_NOISE} run_kind_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int error_count;
    int awaited;
    int tracked_length;

    // Chances in 16 that a burst of idle cycles starts on either side.
    int gap_odds   = 0;
    int stall_odds = 0;
    int sent       = 0;

    positional_array_list u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pal_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .error_count    (error_count),
        .awaited        (awaited),
        .tracked_length (tracked_length)
    );

    // 50 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: ready drops in bursts whose length is drawn at random.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_odds > 0 && $urandom_range(0, 15) < stall_odds) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Possibly leave the request side idle for a burst, with junk on the data lines.
    task automatic maybe_gap();
        int n;
        if (gap_odds > 0 && $urandom_range(0, 15) < gap_odds) begin
            n = $urandom_range(1, 9);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom(), $urandom()});
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Present one request at a falling edge and hold it until the transaction completes.
    task automatic offer(input mode_t op, input int pos, input logic [ITEM_WIDTH-1:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({word, pos[POS_W-1:0], op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_fixed(input mode_t op, input int pos, input logic [ITEM_WIDTH-1:0] word);
        maybe_gap();
        @(negedge aclk);
        offer(op, pos, word);
    endtask

    // Stop sending and wait until every outstanding result has been drained.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
    endtask

    function automatic mode_t choose_mode(input run_kind_t kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            RUN_GROW:   return (r < 70) ? MODE_INSERT : (r < 85) ? MODE_READ :
                               (r < 95) ? MODE_DELETE : MODE_NOP;
            RUN_SHRINK: return (r < 65) ? MODE_DELETE : (r < 85) ? MODE_READ :
                               (r < 95) ? MODE_INSERT : MODE_NOP;
            RUN_FILL:   return (tracked_length < CAPACITY) ? MODE_INSERT :
                               mode_t'($urandom_range(0, 3));
            default:    return mode_t'($urandom_range(0, 3));
        endcase
    endfunction

    // Mostly valid positions with the ends favored; some zero, one past the end
    // and anything the field can hold.
    function automatic int choose_position(input run_kind_t kind, input mode_t op);
        int limit;
        int r;
        limit = (op == MODE_INSERT) ? tracked_length + 1 : tracked_length;
        r     = $urandom_range(0, 99);
        if (kind == RUN_NOISE || limit == 0 || r < 10)
            return $urandom_range(0, 127);
        if (r < 15) return 0;
        if (r < 20) return limit + 1;
        if (r < 35) return 1;
        if (r < 50) return limit;
        return $urandom_range(1, limit);
    endfunction

    function automatic logic [ITEM_WIDTH-1:0] choose_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic int choose_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 5;
            default: return 10;
        endcase
    endfunction

    initial begin
        run_kind_t kind;
        int        run_len;
        int        r;
        mode_t     op;
        bit        paused;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        paused   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty list, bad positions, both ends and the middle.
        gap_odds   = 4;
        stall_odds = 4;
        send_fixed(MODE_READ,   1,   32'h1234_5678);
        send_fixed(MODE_DELETE, 1,   '0);
        send_fixed(MODE_READ,   0,   '0);
        send_fixed(MODE_INSERT, 0,   32'hDEAD_BEEF);
        send_fixed(MODE_INSERT, 2,   32'hDEAD_BEEF);
        send_fixed(MODE_INSERT, 127, '1);
        send_fixed(MODE_NOP,    1,   32'hCAFE_F00D);
        send_fixed(MODE_INSERT, 1,   '0);
        send_fixed(MODE_INSERT, 1,   '1);
        send_fixed(MODE_INSERT, 3,   32'hA5A5_A5A5);
        send_fixed(MODE_INSERT, 2,   32'h5A5A_5A5A);
        send_fixed(MODE_READ,   0,   '0);
        send_fixed(MODE_READ,   5,   '0);
        send_fixed(MODE_READ,   127, '1);
        for (int p = 1; p <= 4; p++)
            send_fixed(MODE_READ, p, '0);
        send_fixed(MODE_DELETE, 0,   '0);
        send_fixed(MODE_DELETE, 5,   '0);
        send_fixed(MODE_DELETE, 2,   '0);
        send_fixed(MODE_DELETE, 3,   '0);
        send_fixed(MODE_NOP,    127, '1);
        send_fixed(MODE_DELETE, 1,   '0);
        send_fixed(MODE_READ,   1,   '0);

        // Random part in runs that push the list up, down, to full, or just poke it.
        while (sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 9);
            kind = (r < 4) ? RUN_GROW : (r < 7) ? RUN_SHRINK : (r < 8) ? RUN_FILL : RUN_NOISE;
            run_len = (kind == RUN_FILL) ? CAPACITY + 16 : $urandom_range(4, 40);
            if (sent >= QUIET_FROM) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                gap_odds   = choose_odds();
                stall_odds = choose_odds();
            end
            // Once half of the items have been sent, let the result side empty completely before going on.
            if (!paused && sent >= TOTAL_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
            for (int k = 0; k < run_len && sent < TOTAL_ITEMS; k++) begin
                maybe_gap();
                @(negedge aclk);
                op = choose_mode(kind);
                offer(op, choose_position(kind, op), choose_word());
            end
        end

        // Let the last results drain, then wait for any strays before the verdict.
        drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
